// File: design/khte_pkg.sv
// ----------------------------------------------------------------------------
// khte_pkg
// Shared types, codes and defaults for the keyed hash table engine.
// ----------------------------------------------------------------------------
package khte_pkg;

  localparam int BUCKETS_DEF = 256;
  localparam int WAYS_DEF    = 4;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // request kinds
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_FIND   = 2'd3;

  // response status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_KEY_ZERO  = 3'd3;
  localparam logic [2:0] ST_NO_BLOCK  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] data;
    logic [31:0] block_len;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data_out;
    logic [31:0] free_key;
  } rsp_t;

  // one way of a bucket row
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] data;
  } way_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_READ,
    S_UPDATE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic mul1;
    logic mul2;
    logic read;
    logic update;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// File: design/khte_ctrl.sv
// ----------------------------------------------------------------------------
// khte_ctrl
// Sequencer: clear sweep after reset, then hash, read, update per request.
// ----------------------------------------------------------------------------
module khte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  khte_pkg::sts_t sts,
  output khte_pkg::cmd_t cmd
);
  import khte_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold the bucket row until the output register frees up
        if (sts.out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// File: design/khte_dp.sv
// ----------------------------------------------------------------------------
// khte_dp
// Datapath: bucket hash by reciprocal multiply, bucket row memory, way
// match and write-back, highest key and the response register.
// ----------------------------------------------------------------------------
module khte_dp #(
  parameter int BUCKETS = khte_pkg::BUCKETS_DEF,
  parameter int WAYS    = khte_pkg::WAYS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  khte_pkg::cmd_t cmd,
  output khte_pkg::sts_t sts,
  input  khte_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output khte_pkg::rsp_t rsp
);
  import khte_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  // floor(2^32 / BUCKETS); quotient estimate is exact or one low
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
  localparam logic [BW:0] BMOD  = (BW + 1)'(BUCKETS);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

  req_t            req_r;
  logic [31:0]     qest;
  logic [63:0]     prod;
  logic [BW:0]     qb;
  logic [BW:0]     rem0;
  logic [BW:0]     rem1;
  logic [BW-1:0]   bucket;
  logic [BW-1:0]   bucket_r;
  logic [BW-1:0]   clr_cnt;
  logic [31:0]     highest;
  logic [31:0]     highest_next;

  way_t [WAYS-1:0] mem [BUCKETS];
  way_t [WAYS-1:0] row;
  way_t [WAYS-1:0] row_next;
  logic            mem_we;
  logic [BW-1:0]   mem_waddr;
  way_t [WAYS-1:0] mem_wdata;

  logic [WAYS-1:0] hit;
  logic [WAYS-1:0] vld;
  logic [WAYS-1:0] free_oh;
  logic [31:0]     hit_data;
  logic            upd_we;
  rsp_t            rsp_next;

  // --- hashing --------------------------------------------------------------
  assign prod = req_r.key * RECIP;
  assign rem0 = req_r.key[BW:0] - qb;
  assign rem1 = (rem0 >= BMOD) ? rem0 - BMOD : rem0;
  assign bucket = rem1[BW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
    end
    if (cmd.mul1) begin
      qest <= prod[63:32];
    end
    if (cmd.mul2) begin
      qb <= qest[BW:0] * BMOD;
    end
    if (cmd.read) begin
      bucket_r <= bucket;
    end
  end

  // --- clear sweep counter --------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt == LAST_ROW);

  // --- bucket memory --------------------------------------------------------
  always_comb begin
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.update && upd_we;
      mem_waddr = bucket_r;
      mem_wdata = row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      row <= mem[bucket];
    end
  end

  // --- way match and update -------------------------------------------------
  always_comb begin
    hit      = '0;
    vld      = '0;
    hit_data = '0;
    for (int w = 0; w < WAYS; w++) begin
      vld[w] = row[w].valid;
      hit[w] = row[w].valid && (row[w].key == req_r.key);
      if (hit[w]) begin
        hit_data = hit_data | row[w].data;
      end
    end
    // lowest clear bit of the valid vector
    free_oh = ~vld & (vld + 1'b1);
  end

  always_comb begin
    row_next     = row;
    upd_we       = 1'b0;
    highest_next = highest;
    rsp_next     = '{status: ST_OK, data_out: '0, free_key: '0};
    if (req_r.req_type == REQ_FIND) begin
      if ((ALL_ONES - req_r.block_len) > highest) begin
        rsp_next.free_key = highest + 32'd1;
      end else begin
        rsp_next.status = ST_NO_BLOCK;
      end
    end else if (req_r.key == '0) begin
      rsp_next.status = ST_KEY_ZERO;
    end else begin
      case (req_r.req_type)
        REQ_LOOKUP: begin
          if (|hit) begin
            rsp_next.data_out = hit_data;
          end else begin
            rsp_next.status = ST_NOT_FOUND;
          end
        end
        REQ_INSERT: begin
          if (req_r.key > highest) begin
            highest_next = req_r.key;
          end
          if (|hit) begin
            upd_we = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
              if (hit[w]) begin
                row_next[w].data = req_r.data;
              end
            end
          end else if (|free_oh) begin
            upd_we = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
              if (free_oh[w]) begin
                row_next[w] = '{valid: 1'b1, key: req_r.key, data: req_r.data};
              end
            end
          end else begin
            rsp_next.status = ST_FULL;
          end
        end
        REQ_REMOVE: begin
          if (|hit) begin
            upd_we = 1'b1;
            for (int w = 0; w < WAYS; w++) begin
              if (hit[w]) begin
                row_next[w].valid = 1'b0;
              end
            end
          end else begin
            rsp_next.status = ST_NOT_FOUND;
          end
        end
        default: begin
          rsp_next.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '0;
    end else if (cmd.update) begin
      highest <= highest_next;
    end
  end

  // --- response register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.update) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp <= rsp_next;
    end
  end

  assign sts.out_free = !rsp_valid || rsp_ready;

endmodule

// File: design/keyed_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// keyed_hash_table_engine_unit
// Key-to-handle map: lookup, insert, remove and find-free-key-block
// requests over a bucketed, set-associative table of 32-bit keys.
// ----------------------------------------------------------------------------
//
//   channel | signals                       | moves
//   --------+-------------------------------+--------------------------------
//   req     | req_valid, req_ready, req     | one request per transfer
//   rsp     | rsp_valid, rsp_ready, rsp     | one response per request
//
// Sequence: a request passes through accept, two hash multiplies, bucket row
//   read, update and write-back before the next request transfer. The bucket
//   row memory's single read/write port and the two-step reciprocal multiply
//   for key mod BUCKETS set this order.
// Reset: synchronous, active high. After reset a clearing pass zeroes the
//   valid bits of all BUCKETS rows, one row per cycle; req_ready stays low
//   until it finishes.
// Stalls: the response sits in an output register; a new request is taken
//   while it waits, and the update step holds if the register is still full.
// ----------------------------------------------------------------------------
module keyed_hash_table_engine_unit #(
  parameter int BUCKETS = khte_pkg::BUCKETS_DEF,
  parameter int WAYS    = khte_pkg::WAYS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  khte_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output khte_pkg::rsp_t rsp
);
  import khte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the clear sweep and the per-request step order
  khte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hash, bucket memory, match/update logic and response register
  khte_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: design/khte_checker.sv
// ----------------------------------------------------------------------------
// khte_checker
// Port-level checks for the keyed hash table engine, bound to the top level.
// ----------------------------------------------------------------------------
module khte_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input khte_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input khte_pkg::rsp_t rsp
);
  import khte_pkg::*;

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // the engine works on one request at a time
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a handle only comes back with a successful lookup
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.data_out != 32'd0) |-> rsp.status == ST_OK && rsp.free_key == 32'd0)
    else $error("data_out set on a failed or non-lookup response");

  // a free key only comes back with a successful find
  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.free_key != 32'd0) |-> rsp.status == ST_OK && rsp.data_out == 32'd0)
    else $error("free_key set on a failed or non-find response");

endmodule

bind keyed_hash_table_engine_unit khte_checker u_khte_checker (.*);
